// ===== src/sawl_pkg.sv =====
`default_nettype none

package sawl_pkg;

  localparam int unsigned CmdW = 3;
  localparam int unsigned ByteW = 8;
  localparam int unsigned TimerW = 16;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CmdW-1:0] CMD_PACKET_READY   = 3'd0;
  localparam logic [CmdW-1:0] CMD_FRAME_ARRIVAL  = 3'd1;
  localparam logic [CmdW-1:0] CMD_TICK           = 3'd2;
  localparam logic [CmdW-1:0] CMD_CHANNEL_IDLE   = 3'd3;
  localparam logic [CmdW-1:0] CMD_CHECKSUM_ERROR = 3'd4;

  // register index as seen on the config port (paddr[2])
  localparam logic REG_TIMEOUT_TICKS = 1'b0;

  localparam logic [TimerW-1:0] TIMEOUT_RESET = 16'd13;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [ByteW-1:0] net_byte;
    logic             channel_free;
    logic [ByteW-1:0] rx_info;
    logic             rx_is_data;
    logic             rx_seq;
    logic             rx_ack;
  } in_item_t;

  typedef struct packed {
    logic             tx_valid;
    logic [ByteW-1:0] tx_info;
    logic             tx_is_data;
    logic             tx_seq;
    logic             tx_ack;
    logic             deliver_valid;
    logic [ByteW-1:0] deliver_byte;
    logic             net_ready;
    logic             timer_active;
  } out_item_t;

endpackage

`default_nettype wire

// ===== src/sawl_cfg.sv =====
`default_nettype none

module sawl_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [sawl_pkg::CfgAddrW-1:0]  paddr,
  input  wire logic [sawl_pkg::CfgDataW-1:0]  pwdata,
  output logic      [sawl_pkg::CfgDataW-1:0]  prdata,
  output logic                                pready,
  output logic      [sawl_pkg::TimerW-1:0]    timeout_ticks
);
  import sawl_pkg::*;

  logic [TimerW-1:0] timeout_r;
  logic [TimerW-1:0] timeout_nxt;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    timeout_nxt = timeout_r;
    if (wr_en && (paddr[2] == REG_TIMEOUT_TICKS)) begin
      timeout_nxt = pwdata[TimerW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else begin
      timeout_r <= timeout_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TIMEOUT_TICKS) begin
      prdata = {{(CfgDataW-TimerW){1'b0}}, timeout_r};
    end
  end

  assign timeout_ticks = timeout_r;

endmodule

`default_nettype wire

// ===== src/sawl_core.sv =====
`default_nettype none

module sawl_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         step,
  input  wire sawl_pkg::in_item_t           item,
  input  wire logic [sawl_pkg::TimerW-1:0]  timeout_ticks,
  output sawl_pkg::out_item_t               res
);
  import sawl_pkg::*;

  logic              next_to_send_r,  next_to_send_nxt;
  logic              expected_seq_r,  expected_seq_nxt;
  logic [ByteW-1:0]  held_byte_r,     held_byte_nxt;
  logic              send_pending_r,  send_pending_nxt;
  logic              net_enabled_r,   net_enabled_nxt;
  logic              timer_running_r, timer_running_nxt;
  logic [TimerW-1:0] timer_left_r,    timer_left_nxt;
  logic [TimerW-1:0] timer_dec;
  logic              emit_data;

  assign timer_dec = (timer_left_r != '0) ? timer_left_r - 1'b1 : timer_left_r;

  always_comb begin
    next_to_send_nxt  = next_to_send_r;
    expected_seq_nxt  = expected_seq_r;
    held_byte_nxt     = held_byte_r;
    send_pending_nxt  = send_pending_r;
    net_enabled_nxt   = net_enabled_r;
    timer_running_nxt = timer_running_r;
    timer_left_nxt    = timer_left_r;
    emit_data         = 1'b0;
    res               = '0;

    unique case (item.command)
      CMD_PACKET_READY: begin
        if (net_enabled_r) begin
          held_byte_nxt   = item.net_byte;
          net_enabled_nxt = 1'b0;
          if (item.channel_free) begin
            emit_data        = 1'b1;
            send_pending_nxt = 1'b0;
          end else begin
            send_pending_nxt = 1'b1;
          end
        end
      end
      CMD_FRAME_ARRIVAL: begin
        if (item.rx_is_data && (item.rx_seq == expected_seq_r)) begin
          res.deliver_valid = 1'b1;
          res.deliver_byte  = item.rx_info;
          expected_seq_nxt  = ~expected_seq_r;
          if (item.channel_free) begin
            // ack-only frame
            res.tx_valid = 1'b1;
            res.tx_ack   = item.rx_seq;
          end
        end
        if (item.rx_ack == next_to_send_r) begin
          timer_running_nxt = 1'b0;
          net_enabled_nxt   = 1'b1;
          next_to_send_nxt  = ~next_to_send_r;
        end
      end
      CMD_TICK: begin
        if (timer_running_r) begin
          timer_left_nxt = timer_dec;
          if (timer_dec == '0) begin
            emit_data = 1'b1;
          end
        end
      end
      CMD_CHANNEL_IDLE: begin
        if (send_pending_r) begin
          emit_data        = 1'b1;
          send_pending_nxt = 1'b0;
        end
      end
      default: begin
        // checksum error and unused codes
      end
    endcase

    if (emit_data) begin
      // data frame carries the held byte, including one latched this step on a packet offer
      res.tx_valid      = 1'b1;
      res.tx_info       = held_byte_nxt;
      res.tx_is_data    = 1'b1;
      res.tx_seq        = next_to_send_r;
      res.tx_ack        = ~expected_seq_r;
      timer_left_nxt    = timeout_ticks;
      timer_running_nxt = 1'b1;
    end

    res.net_ready    = net_enabled_nxt;
    res.timer_active = timer_running_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_to_send_r  <= 1'b0;
      expected_seq_r  <= 1'b0;
      held_byte_r     <= '0;
      send_pending_r  <= 1'b0;
      net_enabled_r   <= 1'b1;
      timer_running_r <= 1'b0;
      timer_left_r    <= '0;
    end else if (step) begin
      next_to_send_r  <= next_to_send_nxt;
      expected_seq_r  <= expected_seq_nxt;
      held_byte_r     <= held_byte_nxt;
      send_pending_r  <= send_pending_nxt;
      net_enabled_r   <= net_enabled_nxt;
      timer_running_r <= timer_running_nxt;
      timer_left_r    <= timer_left_nxt;
    end
  end

  a_tick_expiry_reload: assert property (@(posedge clk) disable iff (!rst_n)
    step && (item.command == CMD_TICK) && timer_running_r && (timer_left_r <= 16'd1)
    |=> timer_running_r && (timer_left_r == $past(timeout_ticks)))
    else $error("timer not reloaded on expiry");

  a_data_starts_timer: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.tx_valid && res.tx_is_data |=> timer_running_r)
    else $error("data frame sent without running timer");

  a_deliver_toggles: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.deliver_valid |=> expected_seq_r != $past(expected_seq_r))
    else $error("delivery without expected_seq toggle");

  a_idle_tick_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    step && (item.command == CMD_TICK) && !timer_running_r
    |-> !res.tx_valid && !res.deliver_valid)
    else $error("tick with stopped timer produced output");

  a_hold_when_no_step: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(timer_left_r) && $stable(next_to_send_r) && $stable(expected_seq_r))
    else $error("link state changed without a step");

endmodule

`default_nettype wire

// ===== src/stop_and_wait_arq_link.sv =====
`default_nettype none

// Stop-and-wait ARQ link controller, one-bit sequence numbers, piggybacked acks.
//
// in_*  : one request per event (packet offer, frame in, tick,
//         line idle, checksum error) with valid/ready handshake.
// out_* : exactly one response per request: frame to send (if any), byte
//         delivered to the network side (if any), net_ready, timer_active.
// cfg_* : APB-style port; timeout_ticks at byte address 0 (reset 13).
//         Write only while no request is in flight.
//
// Throughput: one request per cycle while out_ready is high; the event decode
// and state update is a single pass of logic between the input and output
// registers. When out_ready is low the response holds in the output register,
// one more request is still taken into the input register, then in_ready drops.
// Reset (synchronous, rst_n low): both stages empty, link state as at power
// up (sequence bits 0, network side enabled, timer stopped).
module stop_and_wait_arq_link (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire sawl_pkg::in_item_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output sawl_pkg::out_item_t                out_data,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [sawl_pkg::CfgAddrW-1:0] cfg_paddr,
  input  wire logic [sawl_pkg::CfgDataW-1:0] cfg_pwdata,
  output logic      [sawl_pkg::CfgDataW-1:0] cfg_prdata,
  output logic                               cfg_pready
);
  import sawl_pkg::*;

  logic              in_valid_r, in_valid_nxt;
  in_item_t          in_item_r;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r;
  out_item_t         step_res;
  logic              step;
  logic [TimerW-1:0] timeout_ticks;

  sawl_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (cfg_psel),
    .penable       (cfg_penable),
    .pwrite        (cfg_pwrite),
    .paddr         (cfg_paddr),
    .pwdata        (cfg_pwdata),
    .prdata        (cfg_prdata),
    .pready        (cfg_pready),
    .timeout_ticks (timeout_ticks)
  );

  // request in the input register moves on whenever the output slot frees
  assign step     = in_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~in_valid_r | step;

  sawl_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .item          (in_item_r),
    .timeout_ticks (timeout_ticks),
    .res           (step_res)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
    end else if (step) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
    if (step) begin
      out_item_r <= step_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_item_r))
    else $error("response changed while stalled");

  a_no_step_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !step)
    else $error("step taken into a full output register");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("input accepted with both stages full");

endmodule

`default_nettype wire
